@@ rtl/core/nrlp_pkg.sv @@
// ----------------------------------------------------------------------------
// nrlp_pkg
// Shared types and constants for the number range list parser.
// ----------------------------------------------------------------------------
package nrlp_pkg;

	localparam int VAL_W  = 31;
	localparam int POS_W  = 12;
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_Z     = 8'h7a;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_DASH  = 8'h2d;

	localparam logic [VAL_W+3:0] NUM_BASE = 35'd10;

	typedef enum logic [1:0] {
		PH_TOP   = 2'd0,
		PH_NUM   = 2'd1,
		PH_AFTER = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		KIND_SEG = 2'd0,
		KIND_OK  = 2'd1,
		KIND_ERR = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		ERR_NONE     = 4'd0,
		ERR_DIGIT    = 4'd1,
		ERR_Z        = 4'd2,
		ERR_R        = 4'd3,
		ERR_SEP      = 4'd4,
		ERR_DASH     = 4'd5,
		ERR_CHAR     = 4'd6,
		ERR_NUMBER   = 4'd7,
		ERR_RANGE    = 4'd8,
		ERR_OVERFLOW = 4'd9
	} err_t;

	typedef struct packed {
		kind_t             kind;
		logic [VAL_W-1:0]  first;
		logic [VAL_W-1:0]  last;
		err_t              code;
		logic              has_pos;
		logic [POS_W-1:0]  pos;
		logic              is_last;
	} result_t;

	// up to two words per parsed character; second only with first
	typedef struct packed {
		logic    p0;
		logic    p1;
		result_t r0;
		result_t r1;
	} push_t;

endpackage

@@ rtl/core/nrlp_parse.sv @@
// ----------------------------------------------------------------------------
// nrlp_parse
// Parse state and per-character update; produces segment and status words.
// ----------------------------------------------------------------------------
module nrlp_parse #(
	parameter int MAX_TEXT_LEN = 4096
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	input  logic [7:0]                 ch,
	input  logic                       eos,
	input  logic [nrlp_pkg::VAL_W-1:0] max_value,
	output nrlp_pkg::push_t            push
);

	localparam int IW = $clog2(MAX_TEXT_LEN);
	localparam logic [IW-1:0] IDX_MAX = IW'(MAX_TEXT_LEN - 1);

	nrlp_pkg::phase_t            phase_q, phase_n;
	logic                        after_dash_q, after_dash_n;
	logic                        cfe_q, cfe_n;
	logic [nrlp_pkg::VAL_W-1:0]  accum_q, accum_n;
	logic [nrlp_pkg::VAL_W-1:0]  prev_q, prev_n;
	logic [IW-1:0]               idx_q, idx_n;
	nrlp_pkg::err_t              syn_q, syn_n;
	logic [IW-1:0]               syn_idx_q, syn_idx_n;
	logic                        range_q, range_n;
	logic                        ovf_q, ovf_n;

	logic                        is_digit;
	logic                        ph_top;
	logic [nrlp_pkg::VAL_W+3:0]  mul;
	logic [nrlp_pkg::VAL_W:0]    rev_v;
	logic [nrlp_pkg::VAL_W-1:0]  term_v;
	logic                        term_range;
	logic [IW+nrlp_pkg::POS_W-1:0] pos_ext;
	nrlp_pkg::result_t           seg;
	nrlp_pkg::result_t           status;
	logic                        rng_eos;
	logic                        emit_eos;

	assign is_digit = (ch >= nrlp_pkg::CH_ZERO) && (ch <= nrlp_pkg::CH_NINE);
	assign ph_top   = !(phase_q == nrlp_pkg::PH_NUM || phase_q == nrlp_pkg::PH_AFTER);
	assign mul      = {4'b0, accum_q} * nrlp_pkg::NUM_BASE
	                  + {{nrlp_pkg::VAL_W{1'b0}}, ch[3:0]};

	// term value, counting from the end when r-prefixed
	assign rev_v = {1'b0, max_value} + {{nrlp_pkg::VAL_W{1'b0}}, 1'b1}
	               - {1'b0, accum_q};
	always_comb begin
		if (!cfe_q) begin
			term_v = accum_q;
		end else if (accum_q > max_value) begin
			term_v = '0;
		end else if (rev_v[nrlp_pkg::VAL_W]) begin
			term_v = nrlp_pkg::VAL_MAX;
		end else begin
			term_v = rev_v[nrlp_pkg::VAL_W-1:0];
		end
	end
	assign term_range = (max_value != '0) && ((term_v == '0) || (term_v > max_value));

	assign pos_ext = {{nrlp_pkg::POS_W{1'b0}}, syn_n == syn_q ? syn_idx_q : idx_q};

	always_comb begin
		seg         = '0;
		seg.kind    = nrlp_pkg::KIND_SEG;
		seg.code    = nrlp_pkg::ERR_NONE;
		seg.first   = after_dash_q ? prev_q : term_v;
		seg.last    = term_v;
	end

	always_comb begin
		rng_eos  = range_q;
		emit_eos = 1'b0;
		if (syn_q == nrlp_pkg::ERR_NONE && !ph_top) begin
			rng_eos  = range_q | term_range;
			emit_eos = !(rng_eos || ovf_q);
		end
	end

	always_comb begin
		status         = '0;
		status.is_last = 1'b1;
		status.kind    = nrlp_pkg::KIND_ERR;
		status.code    = nrlp_pkg::ERR_NONE;
		if (syn_n != nrlp_pkg::ERR_NONE) begin
			status.code    = syn_n;
			status.has_pos = 1'b1;
			status.pos     = pos_ext[nrlp_pkg::POS_W-1:0];
		end else if (ovf_q) begin
			status.code = nrlp_pkg::ERR_OVERFLOW;
		end else if (rng_eos) begin
			status.code = nrlp_pkg::ERR_RANGE;
		end else begin
			status.kind = nrlp_pkg::KIND_OK;
		end
	end

	always_comb begin
		push    = '0;
		push.r0 = seg;
		push.r1 = status;
		if (item_valid && eos) begin
			push.p0 = 1'b1;
			if (emit_eos) begin
				push.p1 = 1'b1;
			end else begin
				push.r0 = status;
			end
		end else if (item_valid && syn_q == nrlp_pkg::ERR_NONE && !ph_top
		             && ch == nrlp_pkg::CH_COMMA) begin
			push.p0 = !(range_q || term_range || ovf_q);
		end
	end

	always_comb begin
		phase_n      = phase_q;
		after_dash_n = after_dash_q;
		cfe_n        = cfe_q;
		accum_n      = accum_q;
		prev_n       = prev_q;
		idx_n        = idx_q;
		syn_n        = syn_q;
		syn_idx_n    = syn_idx_q;
		range_n      = range_q;
		ovf_n        = ovf_q;

		if (item_valid && eos) begin
			if (syn_q == nrlp_pkg::ERR_NONE && ph_top) begin
				syn_n = nrlp_pkg::ERR_NUMBER;
			end
		end else if (item_valid) begin
			if (syn_q == nrlp_pkg::ERR_NONE) begin
				if (is_digit) begin
					if (phase_q == nrlp_pkg::PH_AFTER) begin
						syn_n     = nrlp_pkg::ERR_DIGIT;
						syn_idx_n = idx_q;
					end else begin
						if (mul > {4'b0, nrlp_pkg::VAL_MAX}) begin
							accum_n = nrlp_pkg::VAL_MAX;
							ovf_n   = 1'b1;
						end else begin
							accum_n = mul[nrlp_pkg::VAL_W-1:0];
						end
						phase_n = nrlp_pkg::PH_NUM;
					end
				end else if (ch == nrlp_pkg::CH_Z) begin
					if (!ph_top) begin
						syn_n     = nrlp_pkg::ERR_Z;
						syn_idx_n = idx_q;
					end else begin
						accum_n = max_value;
						phase_n = nrlp_pkg::PH_AFTER;
					end
				end else if (ch == nrlp_pkg::CH_R) begin
					if (!ph_top) begin
						syn_n     = nrlp_pkg::ERR_R;
						syn_idx_n = idx_q;
					end else begin
						cfe_n   = 1'b1;
						phase_n = nrlp_pkg::PH_NUM;
					end
				end else if (ch == nrlp_pkg::CH_COMMA || ch == nrlp_pkg::CH_DASH) begin
					if (ph_top) begin
						syn_n     = nrlp_pkg::ERR_SEP;
						syn_idx_n = idx_q;
					end else if (ch == nrlp_pkg::CH_COMMA) begin
						range_n      = range_q | term_range;
						after_dash_n = 1'b0;
						accum_n      = '0;
						cfe_n        = 1'b0;
						phase_n      = nrlp_pkg::PH_TOP;
					end else if (after_dash_q) begin
						syn_n     = nrlp_pkg::ERR_DASH;
						syn_idx_n = idx_q;
					end else begin
						prev_n       = term_v;
						range_n      = range_q | term_range;
						after_dash_n = 1'b1;
						accum_n      = '0;
						cfe_n        = 1'b0;
						phase_n      = nrlp_pkg::PH_TOP;
					end
				end else begin
					syn_n     = nrlp_pkg::ERR_CHAR;
					syn_idx_n = idx_q;
				end
			end
			if (idx_q < IDX_MAX) begin
				idx_n = idx_q + {{(IW-1){1'b0}}, 1'b1};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= nrlp_pkg::PH_TOP;
			after_dash_q <= 1'b0;
			cfe_q        <= 1'b0;
			accum_q      <= '0;
			prev_q       <= '0;
			idx_q        <= '0;
			syn_q        <= nrlp_pkg::ERR_NONE;
			syn_idx_q    <= '0;
			range_q      <= 1'b0;
			ovf_q        <= 1'b0;
		end else if (item_valid && eos) begin
			phase_q      <= nrlp_pkg::PH_TOP;
			after_dash_q <= 1'b0;
			cfe_q        <= 1'b0;
			accum_q      <= '0;
			prev_q       <= '0;
			idx_q        <= '0;
			syn_q        <= nrlp_pkg::ERR_NONE;
			syn_idx_q    <= '0;
			range_q      <= 1'b0;
			ovf_q        <= 1'b0;
		end else begin
			phase_q      <= phase_n;
			after_dash_q <= after_dash_n;
			cfe_q        <= cfe_n;
			accum_q      <= accum_n;
			prev_q       <= prev_n;
			idx_q        <= idx_n;
			syn_q        <= syn_n;
			syn_idx_q    <= syn_idx_n;
			range_q      <= range_n;
			ovf_q        <= ovf_n;
		end
	end

endmodule

@@ rtl/core/nrlp_outq.sv @@
// ----------------------------------------------------------------------------
// nrlp_outq
// Result queue: takes up to two words a cycle, hands out one.
// ----------------------------------------------------------------------------
module nrlp_outq (
	input  logic              clk,
	input  logic              arst_n,
	input  nrlp_pkg::push_t   push,
	input  logic              pop,
	output logic              room,
	output logic              head_valid,
	output nrlp_pkg::result_t head
);

	nrlp_pkg::result_t              mem_q [nrlp_pkg::QDEPTH];
	logic [nrlp_pkg::QPTR_W-1:0]    wr_q;
	logic [nrlp_pkg::QPTR_W-1:0]    rd_q;
	logic [nrlp_pkg::QCNT_W-1:0]    cnt_q;
	logic [nrlp_pkg::QPTR_W-1:0]    wr_nxt;
	logic [nrlp_pkg::QCNT_W-1:0]    n_in;
	logic [nrlp_pkg::QCNT_W-1:0]    n_out;

	assign wr_nxt     = wr_q + {{(nrlp_pkg::QPTR_W-1){1'b0}}, 1'b1};
	assign n_in       = {{(nrlp_pkg::QCNT_W-1){1'b0}}, push.p0}
	                    + {{(nrlp_pkg::QCNT_W-1){1'b0}}, push.p1};
	assign n_out      = {{(nrlp_pkg::QCNT_W-1){1'b0}}, pop};
	assign room       = cnt_q <= nrlp_pkg::QCNT_W'(nrlp_pkg::QDEPTH - 2);
	assign head_valid = cnt_q != '0;
	assign head       = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push.p0) begin
			mem_q[wr_q] <= push.r0;
		end
		if (push.p1) begin
			mem_q[wr_nxt] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + n_in[nrlp_pkg::QPTR_W-1:0];
			rd_q  <= rd_q + {{(nrlp_pkg::QPTR_W-1){1'b0}}, pop};
			cnt_q <= cnt_q + n_in - n_out;
		end
	end

endmodule

@@ rtl/core/number_range_list_parser_top.sv @@
// ----------------------------------------------------------------------------
// number_range_list_parser_top
// Range list parser: one character per word in, segments and final status out.
// ----------------------------------------------------------------------------
// The input word is registered; its result words go to the port via the queue.
// Throughput: one character per cycle while not stalled; an end-of-string word
// that closes a term gives two result words through the 4-word result queue,
// which holds off input while fewer than two entries are free.
// Reset: parse state cleared, max_value 0, result queue empty.
module number_range_list_parser_top #(
	parameter int MAX_TEXT_LEN = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  ch,
	input  logic        end_of_string,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  result_kind,
	output logic [30:0] seg_first,
	output logic [30:0] seg_last,
	output logic [3:0]  error_code,
	output logic        error_has_position,
	output logic [11:0] error_position,
	output logic        is_last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [30:0] cfg_data
);

	logic                        valid_s1;
	logic [7:0]                  ch_s1;
	logic                        eos_s1;
	logic                        advance;
	logic                        room;
	logic                        accept;
	logic [nrlp_pkg::VAL_W-1:0]  max_value_q;
	nrlp_pkg::push_t             push;
	nrlp_pkg::result_t           head;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && room;
	assign in_stall  = valid_s1 && !room;
	assign accept    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_value_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			max_value_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_s1  <= ch;
			eos_s1 <= end_of_string;
		end
	end

	nrlp_parse #(
		.MAX_TEXT_LEN(MAX_TEXT_LEN)
	) u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (advance),
		.ch         (ch_s1),
		.eos        (eos_s1),
		.max_value  (max_value_q),
		.push       (push)
	);

	nrlp_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pop        (out_valid && !out_stall),
		.room       (room),
		.head_valid (out_valid),
		.head       (head)
	);

	assign result_kind        = head.kind;
	assign seg_first          = head.first;
	assign seg_last           = head.last;
	assign error_code         = head.code;
	assign error_has_position = head.has_pos;
	assign error_position     = head.pos;
	assign is_last            = head.is_last;

	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with no word held");

	a_err_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == nrlp_pkg::KIND_ERR
		|-> is_last && error_code != nrlp_pkg::ERR_NONE)
		else $error("error status without code or final flag");

	a_seg_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == nrlp_pkg::KIND_SEG
		|-> !is_last && error_code == nrlp_pkg::ERR_NONE && !error_has_position)
		else $error("segment word carries status fields");

	a_pos_syntax: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_has_position
		|-> error_code != nrlp_pkg::ERR_NONE && error_code != nrlp_pkg::ERR_RANGE
		    && error_code != nrlp_pkg::ERR_OVERFLOW)
		else $error("position given for a non-syntax error");

endmodule
